// File: rtl/slc_pkg.sv
package slc_pkg;

  localparam int SLOTS_PER_LINE_DEF = 34;

  localparam int XPOS_W   = 9;
  localparam int PRIO_W   = 2;
  localparam int PAL_W    = 3;
  localparam int PLANES_W = 32;
  localparam int COLOR_W  = 4;
  localparam int ENTRY_W  = 8;
  localparam int LEVEL_W  = 4;
  localparam int COL_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 4;

  // Input item kinds.
  localparam logic [1:0] FUNC_PIXEL      = 2'd0;
  localparam logic [1:0] FUNC_LOAD       = 2'd1;
  localparam logic [1:0] FUNC_LINE_START = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ABOVE_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BELOW_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_ZERO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_THREE = 3'd5;

  // One tile slot as written by a load.
  typedef struct packed {
    logic [XPOS_W-1:0]   xpos;
    logic [PRIO_W-1:0]   prio;
    logic [PAL_W-1:0]    pal;
    logic                mirror;
    logic [PLANES_W-1:0] planes;
  } slot_t;

  // Compositing token that walks down the row of cells.
  typedef struct packed {
    logic               vld;
    logic               stop;
    logic               hit;
    logic [COL_W-1:0]   x;
    logic [ENTRY_W-1:0] entry;
    logic [PRIO_W-1:0]  prio;
  } tok_t;

  // Bank control shared by every cell.
  typedef struct packed {
    logic clr;
    logic wr_bank;
    logic disp_bank;
  } cell_ctl_t;

endpackage

// File: rtl/sprite_line_pixel_compositor.sv
// Channel   | Direction | Handshake              | Payload
// in_       | input     | in_valid / in_ready    | func, tile_xpos, tile_prio, tile_pal,
//           |           |                        | tile_mirror, tile_planes
// out_      | output    | out_valid / out_ready  | above/below palette and priority
// cfg_      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Load, line-start and unused-func transactions complete in the cycle they are
// accepted. A pixel transaction's token walks through the row of cells one cell
// per clock, is parked in a result register, and moves to the output register
// once that is free. in_ready stays low from the pixel's acceptance until its
// result has moved to the output register, so a result waiting on out_ready
// holds off every in_ transaction; cfg_ transactions are still accepted. Reset
// (synchronous, rst_n low) invalidates every slot, selects bank 0 for display
// and clears the counters, palettes and configuration.
module sprite_line_pixel_compositor #(
  parameter int SLOTS_PER_LINE = slc_pkg::SLOTS_PER_LINE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_func,
  input  logic [slc_pkg::XPOS_W-1:0]       in_tile_xpos,
  input  logic [slc_pkg::PRIO_W-1:0]       in_tile_prio,
  input  logic [slc_pkg::PAL_W-1:0]        in_tile_pal,
  input  logic                             in_tile_mirror,
  input  logic [slc_pkg::PLANES_W-1:0]     in_tile_planes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slc_pkg::ENTRY_W-1:0]      out_above_palette,
  output logic [slc_pkg::LEVEL_W-1:0]      out_above_priority,
  output logic [slc_pkg::ENTRY_W-1:0]      out_below_palette,
  output logic [slc_pkg::LEVEL_W-1:0]      out_below_priority,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slc_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int FCW = $clog2(SLOTS_PER_LINE + 1);

  // Configuration registers.
  logic                         above_en_r;
  logic                         below_en_r;
  logic [slc_pkg::LEVEL_W-1:0]  level_r [0:3];

  // Control state.
  logic                         disp_bank_r;
  logic [FCW-1:0]               fill_cnt_r;
  logic [slc_pkg::COL_W-1:0]    column_r;
  logic                         busy_r;

  // A finished token waits here until the output register can take it.
  slc_pkg::tok_t                pend_r;

  logic                         out_valid_r;
  logic [slc_pkg::ENTRY_W-1:0]  above_pal_r;
  logic [slc_pkg::LEVEL_W-1:0]  above_prio_r;
  logic [slc_pkg::ENTRY_W-1:0]  below_pal_r;
  logic [slc_pkg::LEVEL_W-1:0]  below_prio_r;

  logic                         in_acc;
  logic                         do_pixel;
  logic                         do_load;
  logic                         do_line;
  logic                         can_fill;
  logic                         out_free;
  logic                         move_out;
  logic [slc_pkg::LEVEL_W-1:0]  hit_level;

  slc_pkg::cell_ctl_t           ctl;
  slc_pkg::slot_t               wr_slot;
  slc_pkg::tok_t                tok [0:SLOTS_PER_LINE];

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign do_pixel  = in_acc && (in_func == slc_pkg::FUNC_PIXEL);
  assign do_load   = in_acc && (in_func == slc_pkg::FUNC_LOAD);
  assign do_line   = in_acc && (in_func == slc_pkg::FUNC_LINE_START);
  assign can_fill  = fill_cnt_r < FCW'(SLOTS_PER_LINE);

  assign out_free  = !out_valid_r || out_ready;
  assign move_out  = pend_r.vld && out_free;
  assign hit_level = level_r[pend_r.prio];

  // The line start clears the bank that is shown now, which becomes the fill bank.
  assign ctl.clr       = do_line;
  assign ctl.wr_bank   = ~disp_bank_r;
  assign ctl.disp_bank = disp_bank_r;

  assign wr_slot.xpos   = in_tile_xpos;
  assign wr_slot.prio   = in_tile_prio;
  assign wr_slot.pal    = in_tile_pal;
  assign wr_slot.mirror = in_tile_mirror;
  assign wr_slot.planes = in_tile_planes;

  // Token entering the first cell.
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = do_pixel;
    tok[0].x     = column_r;
  end

  for (genvar k = 0; k < SLOTS_PER_LINE; k++) begin : g_cell
    slc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_sel  (do_load && can_fill && (fill_cnt_r == FCW'(k))),
      .wr_slot (wr_slot),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_en_r   <= 1'b0;
      below_en_r   <= 1'b0;
      level_r[0]   <= '0;
      level_r[1]   <= '0;
      level_r[2]   <= '0;
      level_r[3]   <= '0;
      disp_bank_r  <= 1'b0;
      fill_cnt_r   <= '0;
      column_r     <= '0;
      busy_r       <= 1'b0;
      pend_r.vld   <= 1'b0;
      out_valid_r  <= 1'b0;
      above_pal_r  <= '0;
      above_prio_r <= '0;
      below_pal_r  <= '0;
      below_prio_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          slc_pkg::REG_ABOVE_EN:   above_en_r <= cfg_data[0];
          slc_pkg::REG_BELOW_EN:   below_en_r <= cfg_data[0];
          slc_pkg::REG_PRIO_ZERO:  level_r[0] <= cfg_data;
          slc_pkg::REG_PRIO_ONE:   level_r[1] <= cfg_data;
          slc_pkg::REG_PRIO_TWO:   level_r[2] <= cfg_data;
          slc_pkg::REG_PRIO_THREE: level_r[3] <= cfg_data;
          default: ;
        endcase
      end

      if (do_line) begin
        disp_bank_r <= ~disp_bank_r;
        fill_cnt_r  <= '0;
        column_r    <= '0;
      end else if (do_load && can_fill) begin
        fill_cnt_r  <= fill_cnt_r + FCW'(1);
      end else if (do_pixel) begin
        column_r    <= column_r + {{(slc_pkg::COL_W-1){1'b0}}, 1'b1};
      end

      // The token leaves the last cell exactly once per pixel transaction.
      if (tok[SLOTS_PER_LINE].vld) begin
        pend_r <= tok[SLOTS_PER_LINE];
      end else if (move_out) begin
        pend_r.vld <= 1'b0;
      end

      if (do_pixel) begin
        busy_r <= 1'b1;
      end else if (move_out) begin
        busy_r <= 1'b0;
      end

      if (move_out) begin
        out_valid_r  <= 1'b1;
        // Palettes hold their last driven value when the layer shows nothing.
        if (pend_r.hit && above_en_r) begin
          above_pal_r  <= pend_r.entry;
          above_prio_r <= hit_level;
        end else begin
          above_prio_r <= '0;
        end
        if (pend_r.hit && below_en_r) begin
          below_pal_r  <= pend_r.entry;
          below_prio_r <= hit_level;
        end else begin
          below_prio_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_above_palette  = above_pal_r;
  assign out_above_priority = above_prio_r;
  assign out_below_palette  = below_pal_r;
  assign out_below_priority = below_prio_r;

endmodule

// File: rtl/slc_cell.sv
// One slot position of both banks, plus one stage of the compositing token.
module slc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  slc_pkg::cell_ctl_t ctl,
  input  logic              wr_sel,
  input  slc_pkg::slot_t    wr_slot,
  input  slc_pkg::tok_t     tok_in,
  output slc_pkg::tok_t     tok_out
);

  logic [1:0]     valid_r;
  slc_pkg::slot_t slot_r [0:1];
  slc_pkg::tok_t  tok_r;
  slc_pkg::tok_t  tok_nxt;

  slc_pkg::slot_t cur;
  logic           cur_valid;
  logic [10:0]    px;
  logic [2:0]     shift;
  logic [slc_pkg::COLOR_W-1:0] color;

  always_comb begin
    cur       = slot_r[ctl.disp_bank];
    cur_valid = valid_r[ctl.disp_bank];
    px        = {2'b00, tok_in.x} - {{2{cur.xpos[8]}}, cur.xpos};
    shift     = cur.mirror ? px[2:0] : (3'd7 - px[2:0]);
    color     = {cur.planes[{2'd3, shift}], cur.planes[{2'd2, shift}],
                 cur.planes[{2'd1, shift}], cur.planes[{2'd0, shift}]};
    tok_nxt   = tok_in;
    if (tok_in.vld && !tok_in.stop) begin
      if (!cur_valid) begin
        tok_nxt.stop = 1'b1;
      end else if (px[10:3] == 8'd0 && color != '0) begin
        // Later opaque slots overwrite earlier ones.
        tok_nxt.hit   = 1'b1;
        tok_nxt.entry = {1'b1, cur.pal, color};
        tok_nxt.prio  = cur.prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      if (ctl.clr) begin
        // The bank shown up to now becomes the fill bank.
        valid_r[ctl.disp_bank] <= 1'b0;
      end else if (wr_sel) begin
        valid_r[ctl.wr_bank] <= 1'b1;
      end
      tok_r.vld <= tok_nxt.vld;
    end
    if (wr_sel) begin
      slot_r[ctl.wr_bank] <= wr_slot;
    end
    tok_r.stop  <= tok_nxt.stop;
    tok_r.hit   <= tok_nxt.hit;
    tok_r.x     <= tok_nxt.x;
    tok_r.entry <= tok_nxt.entry;
    tok_r.prio  <= tok_nxt.prio;
  end

  assign tok_out = tok_r;

endmodule
